@@ rtl/core/mdrs_pkg.sv @@
package mdrs_pkg;

   // field widths
   localparam int CURRENT_WIDTH  = 10;
   localparam int BATTERY_WIDTH  = 10;
   localparam int THROTTLE_WIDTH = 9;
   localparam int DRIVE_WIDTH    = 8;
   localparam int CAUSE_WIDTH    = 2;
   localparam int STEP_WIDTH     = 4;
   localparam int COUNT_WIDTH    = 8;
   localparam int LEVEL_WIDTH    = 16;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // register defaults
   localparam logic [STEP_WIDTH-1:0]     RAMP_STEP_RESET      = 4'd1;
   localparam logic [CURRENT_WIDTH-1:0]  OC_LEVEL_RESET       = 10'd810;
   localparam logic [COUNT_WIDTH-1:0]    OC_TICKS_RESET       = 8'd5;
   localparam logic [LEVEL_WIDTH-1:0]    BATT_MIN_RESET       = 16'd17856;
   localparam logic [LEVEL_WIDTH-1:0]    LED_LOW_RESET        = 16'd19046;
   localparam logic [LEVEL_WIDTH-1:0]    LED_HIGH_RESET       = 16'd20237;
   localparam logic [LEVEL_WIDTH-1:0]    BATT_AVG_START_RESET = 16'd21427;

   // battery average: sum of 30*avg and sample*64 fits 21 bits
   localparam int SUM_WIDTH   = 21;
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_WIDTH = 22;
   localparam logic [RECIP_WIDTH-1:0] RECIP_31 = RECIP_WIDTH'((64'd1 << RECIP_SHIFT) / 31);
   localparam int QUOT_WIDTH  = SUM_WIDTH + RECIP_WIDTH - RECIP_SHIFT;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RAMP_STEP      = 3'd0,
      CSR_OC_LEVEL       = 3'd1,
      CSR_OC_TICKS       = 3'd2,
      CSR_BATT_MIN       = 3'd3,
      CSR_LED_LOW_LEVEL  = 3'd4,
      CSR_LED_HIGH_LEVEL = 3'd5,
      CSR_BATT_AVG_START = 3'd6
   } csr_index_type;

   // fault causes
   typedef enum logic [CAUSE_WIDTH-1:0] {
      CAUSE_NONE         = 2'd0,
      CAUSE_OVERCURRENT  = 2'd1,
      CAUSE_UNDERVOLTAGE = 2'd2
   } cause_type;

   typedef struct packed {
      logic [STEP_WIDTH-1:0]    ramp_step;
      logic [CURRENT_WIDTH-1:0] oc_level;
      logic [COUNT_WIDTH-1:0]   oc_ticks;
      logic [LEVEL_WIDTH-1:0]   batt_min;
      logic [LEVEL_WIDTH-1:0]   led_low_level;
      logic [LEVEL_WIDTH-1:0]   led_high_level;
   } cfg_type;

   typedef struct packed {
      logic [CURRENT_WIDTH-1:0]         motor_current;
      logic [BATTERY_WIDTH-1:0]         battery_sample;
      logic signed [THROTTLE_WIDTH-1:0] throttle;
   } req_type;

   typedef struct packed {
      logic [DRIVE_WIDTH-1:0] drive_level;
      logic                   fault;
      cause_type              fault_cause;
      logic                   charge_led_low;
      logic                   charge_led_high;
   } rsp_type;

endpackage

@@ rtl/core/mdrs_csr.sv @@
module mdrs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mdrs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mdrs_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output mdrs_pkg::cfg_type                    cfg
);
   import mdrs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register decode; the average start value only matters at reset,
   // which restores its default, so a write to it changes nothing
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RAMP_STEP:      cfg_in.ramp_step      = csr_write_data[STEP_WIDTH-1:0];
            CSR_OC_LEVEL:       cfg_in.oc_level       = csr_write_data[CURRENT_WIDTH-1:0];
            CSR_OC_TICKS:       cfg_in.oc_ticks       = csr_write_data[COUNT_WIDTH-1:0];
            CSR_BATT_MIN:       cfg_in.batt_min       = csr_write_data[LEVEL_WIDTH-1:0];
            CSR_LED_LOW_LEVEL:  cfg_in.led_low_level  = csr_write_data[LEVEL_WIDTH-1:0];
            CSR_LED_HIGH_LEVEL: cfg_in.led_high_level = csr_write_data[LEVEL_WIDTH-1:0];
            CSR_BATT_AVG_START: cfg_in = cfg_ff;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step      <= RAMP_STEP_RESET;
         cfg_ff.oc_level       <= OC_LEVEL_RESET;
         cfg_ff.oc_ticks       <= OC_TICKS_RESET;
         cfg_ff.batt_min       <= BATT_MIN_RESET;
         cfg_ff.led_low_level  <= LED_LOW_RESET;
         cfg_ff.led_high_level <= LED_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/mdrs_tick.sv @@
module mdrs_tick (
   input  logic              clock,
   input  logic              reset,
   input  mdrs_pkg::cfg_type cfg,
   input  logic              advance,
   input  mdrs_pkg::req_type item,
   output mdrs_pkg::rsp_type result
);
   import mdrs_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [LEVEL_WIDTH-1:0] avg_ff, avg_in;
   logic [DRIVE_WIDTH-1:0] drive_ff, drive_in;
   logic                   fault_ff, fault_in;
   cause_type              cause_ff, cause_in;
   logic [1:0]             led_ff, led_in;

   logic [COUNT_WIDTH-1:0]             count_inc;
   logic                               oc_hit;
   logic                               oc_trip;
   logic [LEVEL_WIDTH-1:0]             batt;
   logic [SUM_WIDTH-1:0]               sum;
   logic [SUM_WIDTH+RECIP_WIDTH-1:0]   prod;
   logic [QUOT_WIDTH-1:0]              q0;
   logic [SUM_WIDTH-1:0]               rem;
   logic [QUOT_WIDTH-1:0]              quot;
   logic [LEVEL_WIDTH-1:0]             avg_new;
   logic                               uv_trip;
   logic [1:0]                         led_new;
   logic [DRIVE_WIDTH-1:0]             target;
   logic [DRIVE_WIDTH:0]               up_sum;
   logic [DRIVE_WIDTH-1:0]             up_level;
   logic [STEP_WIDTH+1:0]              down_step;
   logic [DRIVE_WIDTH-1:0]             down_level;
   logic [DRIVE_WIDTH-1:0]             drive_new;

   // overcurrent run length, saturating
   assign count_inc = (count_ff == {COUNT_WIDTH{1'b1}}) ? count_ff : count_ff + 1'b1;
   assign oc_hit    = item.motor_current > cfg.oc_level;
   assign oc_trip   = oc_hit && (count_inc >= cfg.oc_ticks);

   // battery average: (30*avg + sample*64) / 31 by reciprocal and one correction
   assign batt    = {item.battery_sample, 6'd0};
   assign sum     = ({avg_ff, 5'd0} - {4'd0, avg_ff, 1'b0}) + {5'd0, batt};
   assign prod    = {{RECIP_WIDTH{1'b0}}, sum} * {{SUM_WIDTH{1'b0}}, RECIP_31};
   assign q0      = prod[SUM_WIDTH+RECIP_WIDTH-1:RECIP_SHIFT];
   assign rem     = SUM_WIDTH'(sum - ({q0, 5'd0} - {5'd0, q0}));
   assign quot    = (rem >= SUM_WIDTH'(31)) ? q0 + 1'b1 : q0;
   assign avg_new = quot[LEVEL_WIDTH-1:0];
   assign uv_trip = avg_new < cfg.batt_min;

   // charge leds from the raw sample
   assign led_new = {batt > cfg.led_high_level, batt > cfg.led_low_level};

   // ramp toward the throttle; negative throttle counts as zero
   assign target     = item.throttle[THROTTLE_WIDTH-1] ? '0 : item.throttle[DRIVE_WIDTH-1:0];
   assign up_sum     = {1'b0, drive_ff} + {{(DRIVE_WIDTH+1-STEP_WIDTH){1'b0}}, cfg.ramp_step};
   assign up_level   = up_sum[DRIVE_WIDTH] ? {DRIVE_WIDTH{1'b1}} : up_sum[DRIVE_WIDTH-1:0];
   assign down_step  = {2'd0, cfg.ramp_step} + {1'b0, cfg.ramp_step, 1'b0};
   assign down_level = (drive_ff > {2'd0, down_step})
                       ? drive_ff - {2'd0, down_step} : '0;

   always_comb begin
      if (drive_ff < target) begin
         drive_new = up_level;
      end else if (drive_ff > target) begin
         drive_new = down_level;
      end else begin
         drive_new = drive_ff;
      end
   end

   // next state; everything freezes once a fault has latched
   always_comb begin
      count_in = count_ff;
      avg_in   = avg_ff;
      drive_in = drive_ff;
      fault_in = fault_ff;
      cause_in = cause_ff;
      led_in   = led_ff;
      if (!fault_ff) begin
         count_in = oc_hit ? count_inc : '0;
         if (oc_trip) begin
            fault_in = 1'b1;
            cause_in = CAUSE_OVERCURRENT;
            drive_in = '0;
         end else begin
            avg_in = avg_new;
            if (uv_trip) begin
               fault_in = 1'b1;
               cause_in = CAUSE_UNDERVOLTAGE;
               drive_in = '0;
            end else begin
               led_in   = led_new;
               drive_in = drive_new;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         avg_ff   <= BATT_AVG_START_RESET;
         drive_ff <= '0;
         fault_ff <= 1'b0;
         cause_ff <= CAUSE_NONE;
         led_ff   <= '0;
      end else if (advance) begin
         count_ff <= count_in;
         avg_ff   <= avg_in;
         drive_ff <= drive_in;
         fault_ff <= fault_in;
         cause_ff <= cause_in;
         led_ff   <= led_in;
      end
   end

   // result of this item
   always_comb begin
      result.drive_level     = fault_in ? '0 : drive_in;
      result.fault           = fault_in;
      result.fault_cause     = fault_in ? cause_in : CAUSE_NONE;
      result.charge_led_low  = led_in[0];
      result.charge_led_high = led_in[1];
   end

endmodule

@@ rtl/core/motor_drive_ramp_supervisor.sv @@
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | motor_current, battery_sample, throttle
// rsp     | out       | rsp_valid/rsp_stall | drive_level, fault, fault_cause, leds
// csr     | in        | csr_write_enable    | csr_index, csr_write_data
//
// one item per cycle sustained while rsp_stall is low; an item waits in the input
// register, where the tick logic (one 21x22 multiply for the battery average)
// updates state as it moves into the result register
// reset clears all control state and restores register defaults
// req_stall rises only when the input register is full and the result register
// is held by rsp_stall
module motor_drive_ramp_supervisor (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [mdrs_pkg::CURRENT_WIDTH-1:0]         req_motor_current,
   input  logic [mdrs_pkg::BATTERY_WIDTH-1:0]         req_battery_sample,
   input  logic signed [mdrs_pkg::THROTTLE_WIDTH-1:0] req_throttle,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [mdrs_pkg::DRIVE_WIDTH-1:0]           rsp_drive_level,
   output logic                                       rsp_fault,
   output logic [mdrs_pkg::CAUSE_WIDTH-1:0]           rsp_fault_cause,
   output logic                                       rsp_charge_led_low,
   output logic                                       rsp_charge_led_high,
   input  logic                                       csr_write_enable,
   input  logic [mdrs_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [mdrs_pkg::CSR_DATA_WIDTH-1:0]        csr_write_data
);
   import mdrs_pkg::*;

   cfg_type cfg;
   req_type hold_item_ff;
   logic    hold_valid_ff, hold_valid_in;
   rsp_type rsp_item_ff;
   rsp_type tick_result;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;
   logic    advance;
   logic    req_accept;

   mdrs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   mdrs_tick u_tick (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (hold_item_ff),
      .result  (tick_result)
   );

   // handshake between input register and result register
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign advance       = hold_valid_ff && out_free;
   assign req_stall     = hold_valid_ff && !out_free;
   assign req_accept    = req_valid && !req_stall;
   assign hold_valid_in = req_accept || (hold_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         hold_item_ff.motor_current  <= req_motor_current;
         hold_item_ff.battery_sample <= req_battery_sample;
         hold_item_ff.throttle       <= req_throttle;
      end
      if (advance) begin
         rsp_item_ff <= tick_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_level     = rsp_item_ff.drive_level;
   assign rsp_fault           = rsp_item_ff.fault;
   assign rsp_fault_cause     = rsp_item_ff.fault_cause;
   assign rsp_charge_led_low  = rsp_item_ff.charge_led_low;
   assign rsp_charge_led_high = rsp_item_ff.charge_led_high;

endmodule

@@ rtl/core/mdrs_checker.sv @@
module mdrs_checker (
   input logic                                       clock,
   input logic                                       reset,
   input logic                                       rsp_valid,
   input logic                                       rsp_stall,
   input logic [mdrs_pkg::DRIVE_WIDTH-1:0]           rsp_drive_level,
   input logic                                       rsp_fault,
   input logic [mdrs_pkg::CAUSE_WIDTH-1:0]           rsp_fault_cause,
   input logic                                       rsp_charge_led_low,
   input logic                                       rsp_charge_led_high
);
   import mdrs_pkg::*;

   logic seen_fault_ff;

   // remembers that a faulted item has been delivered since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_fault_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_fault) begin
         seen_fault_ff <= 1'b1;
      end
   end

   // a latched fault never clears before reset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_fault_ff |-> rsp_fault)
      else $error("fault cleared without reset");

   // a faulted item always has zero drive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_drive_level == '0)
      else $error("drive not zero while faulted");

   // cause agrees with the fault flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fault == (rsp_fault_cause != CAUSE_NONE))
                    && (rsp_fault_cause == CAUSE_NONE
                        || rsp_fault_cause == CAUSE_OVERCURRENT
                        || rsp_fault_cause == CAUSE_UNDERVOLTAGE))
      else $error("fault cause inconsistent");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_level)
                                 && $stable(rsp_fault) && $stable(rsp_fault_cause)
                                 && $stable(rsp_charge_led_low)
                                 && $stable(rsp_charge_led_high))
      else $error("stalled result changed");

endmodule

bind motor_drive_ramp_supervisor mdrs_checker u_mdrs_checker (.*);
